// ===== rtl/cdiv_pkg.sv =====
// ----------------------------------------------------------------------------
// cdiv_pkg: shared widths and types of the complex divider
// Field widths, internal datapath widths and the struct that carries one
// item through the restoring divider stages.
// ----------------------------------------------------------------------------
package cdiv_pkg;

	localparam int IN_WIDTH   = 16;
	localparam int FRAC_BITS  = 12;
	localparam int OUT_WIDTH  = 24;

	localparam int PROD_W     = 2 * IN_WIDTH;
	localparam int SUM_W      = PROD_W + 1;
	localparam int MAG_W      = PROD_W;
	localparam int DEN_W      = PROD_W;
	localparam int REM_W      = DEN_W + 1;
	localparam int QUO_W      = OUT_WIDTH;
	localparam int NUM_W      = MAG_W + FRAC_BITS;
	localparam int EXT_W      = NUM_W + QUO_W;
	localparam int TOP_W      = NUM_W;
	localparam int CMP_W      = (TOP_W > DEN_W) ? TOP_W : DEN_W;

	// quotient bits resolved per divider stage
	localparam int STEPS      = 2;
	localparam int DIV_STAGES = (QUO_W + STEPS - 1) / STEPS;
	localparam int IDX_W      = $clog2(DIV_STAGES + 1);

	// one quotient part in flight: partial remainder, quotient so far,
	// dividend bits still to bring down, sign and early overflow
	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [QUO_W-1:0] quo;
		logic [QUO_W-1:0] feed;
		logic             neg;
		logic             ovf;
	} part_t;

	typedef struct packed {
		logic             dz;
		logic [DEN_W-1:0] den;
		part_t            re;
		part_t            im;
	} dstage_t;

endpackage

// ===== rtl/cdiv_front.sv =====
// ----------------------------------------------------------------------------
// cdiv_front: products, sums, magnitudes and divider setup
// Four register stages: six multiplies, numerator and denominator sums,
// sign/magnitude split, then overflow check and initial remainder.
// ----------------------------------------------------------------------------
module cdiv_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 conj,
	input  logic signed [cdiv_pkg::IN_WIDTH-1:0] ar,
	input  logic signed [cdiv_pkg::IN_WIDTH-1:0] ai,
	input  logic signed [cdiv_pkg::IN_WIDTH-1:0] br,
	input  logic signed [cdiv_pkg::IN_WIDTH-1:0] bi,
	output logic                                 out_valid,
	output cdiv_pkg::dstage_t                    out_data
);

	// stage 1: products
	logic                               valid_s1;
	logic                               conj_s1;
	logic signed [cdiv_pkg::PROD_W-1:0] prr_s1, pii_s1, pir_s1, pri_s1, pbr_s1, pbi_s1;

	// stage 2: sums
	logic                               valid_s2;
	logic signed [cdiv_pkg::SUM_W-1:0]  nre_s2, nim_s2;
	logic        [cdiv_pkg::DEN_W-1:0]  den_s2;

	// stage 3: sign and magnitude
	logic                               valid_s3;
	logic        [cdiv_pkg::MAG_W-1:0]  mre_s3, mim_s3;
	logic                               sre_s3, sim_s3;
	logic        [cdiv_pkg::DEN_W-1:0]  den_s3;
	logic                               dz_s3;

	// stage 4
	logic                               valid_s4;
	cdiv_pkg::dstage_t                  data_s4;

	logic signed [cdiv_pkg::SUM_W-1:0]  prr_x, pii_x, pir_x, pri_x;
	logic signed [cdiv_pkg::SUM_W-1:0]  nre_abs, nim_abs;

	// split the numerator into the top slice, which sets the overflow check and
	// the first remainder, and the low quotient-width bits fed in step by step
	function automatic cdiv_pkg::part_t init_part(
		input logic [cdiv_pkg::MAG_W-1:0] mag,
		input logic                       neg,
		input logic [cdiv_pkg::DEN_W-1:0] den
	);
		logic [cdiv_pkg::EXT_W-1:0] ext;
		logic [cdiv_pkg::TOP_W-1:0] top;
		logic [cdiv_pkg::CMP_W-1:0] cmp_top;
		logic [cdiv_pkg::CMP_W-1:0] cmp_den;
		cdiv_pkg::part_t            p;
		ext     = cdiv_pkg::EXT_W'(mag) << cdiv_pkg::FRAC_BITS;
		top     = ext[cdiv_pkg::EXT_W-1:cdiv_pkg::QUO_W];
		cmp_top = cdiv_pkg::CMP_W'(top);
		cmp_den = cdiv_pkg::CMP_W'(den);
		p.ovf   = (cmp_top >= cmp_den);
		p.rem   = cmp_top[cdiv_pkg::DEN_W-1:0];
		p.quo   = '0;
		p.feed  = ext[cdiv_pkg::QUO_W-1:0];
		p.neg   = neg;
		return p;
	endfunction

	always_comb begin
		prr_x = {prr_s1[cdiv_pkg::PROD_W-1], prr_s1};
		pii_x = {pii_s1[cdiv_pkg::PROD_W-1], pii_s1};
		pir_x = {pir_s1[cdiv_pkg::PROD_W-1], pir_s1};
		pri_x = {pri_s1[cdiv_pkg::PROD_W-1], pri_s1};
		nre_abs = -nre_s2;
		nim_abs = -nim_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		conj_s1 <= conj;
		prr_s1  <= ar * br;
		pii_s1  <= ai * bi;
		pir_s1  <= ai * br;
		pri_s1  <= ar * bi;
		pbr_s1  <= br * br;
		pbi_s1  <= bi * bi;

		// conjugate divisor flips the sign of the terms in bi
		if (conj_s1) begin
			nre_s2 <= prr_x - pii_x;
			nim_s2 <= pir_x + pri_x;
		end else begin
			nre_s2 <= prr_x + pii_x;
			nim_s2 <= pir_x - pri_x;
		end
		den_s2 <= $unsigned(pbr_s1) + $unsigned(pbi_s1);

		sre_s3 <= nre_s2[cdiv_pkg::SUM_W-1];
		sim_s3 <= nim_s2[cdiv_pkg::SUM_W-1];
		mre_s3 <= nre_s2[cdiv_pkg::SUM_W-1] ? nre_abs[cdiv_pkg::MAG_W-1:0]
		                                    : nre_s2[cdiv_pkg::MAG_W-1:0];
		mim_s3 <= nim_s2[cdiv_pkg::SUM_W-1] ? nim_abs[cdiv_pkg::MAG_W-1:0]
		                                    : nim_s2[cdiv_pkg::MAG_W-1:0];
		den_s3 <= den_s2;
		dz_s3  <= (den_s2 == '0);

		data_s4.dz  <= dz_s3;
		data_s4.den <= den_s3;
		data_s4.re  <= init_part(mre_s3, sre_s3, den_s3);
		data_s4.im  <= init_part(mim_s3, sim_s3, den_s3);
	end

	assign out_valid = valid_s4;
	assign out_data  = data_s4;

endmodule

// ===== rtl/cdiv_div_stage.sv =====
// ----------------------------------------------------------------------------
// cdiv_div_stage: one stage of the restoring divider
// Resolves up to STEPS quotient bits of both parts and registers the result.
// ----------------------------------------------------------------------------
module cdiv_div_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [cdiv_pkg::IDX_W-1:0]   stage_idx,
	input  logic                         in_valid,
	input  cdiv_pkg::dstage_t            in_data,
	output logic                         out_valid,
	output cdiv_pkg::dstage_t            out_data
);

	logic              valid_q;
	cdiv_pkg::dstage_t data_q;
	cdiv_pkg::dstage_t nxt;

	// bring down one dividend bit, subtract the divisor when it fits
	function automatic cdiv_pkg::part_t step_once(
		input cdiv_pkg::part_t            p,
		input logic [cdiv_pkg::DEN_W-1:0] den
	);
		logic [cdiv_pkg::REM_W-1:0] r2;
		logic [cdiv_pkg::REM_W-1:0] dx;
		logic [cdiv_pkg::REM_W-1:0] diff;
		logic                       fit;
		cdiv_pkg::part_t            o;
		r2   = {p.rem, p.feed[cdiv_pkg::QUO_W-1]};
		dx   = {1'b0, den};
		diff = r2 - dx;
		fit  = (r2 >= dx);
		o       = p;
		o.rem   = fit ? diff[cdiv_pkg::DEN_W-1:0] : r2[cdiv_pkg::DEN_W-1:0];
		o.quo   = {p.quo[cdiv_pkg::QUO_W-2:0], fit};
		o.feed  = p.feed << 1;
		return o;
	endfunction

	always_comb begin
		nxt = in_data;
		for (int k = 0; k < cdiv_pkg::STEPS; k++) begin
			// skip steps past the last quotient bit
			if ((int'(stage_idx) * cdiv_pkg::STEPS + k) < cdiv_pkg::QUO_W) begin
				nxt.re = step_once(nxt.re, in_data.den);
				nxt.im = step_once(nxt.im, in_data.den);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ===== rtl/cdiv_back.sv =====
// ----------------------------------------------------------------------------
// cdiv_back: saturation, sign and result register
// Clamps each quotient part, restores its sign, and drives the result strobe.
// ----------------------------------------------------------------------------
module cdiv_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  cdiv_pkg::dstage_t                     in_data,
	output logic                                  out_valid,
	output logic signed [cdiv_pkg::OUT_WIDTH-1:0] out_re,
	output logic signed [cdiv_pkg::OUT_WIDTH-1:0] out_im,
	output logic                                  out_dz,
	output logic                                  out_clip
);

	localparam logic [cdiv_pkg::QUO_W-1:0] HALF = cdiv_pkg::QUO_W'(1) << (cdiv_pkg::QUO_W - 1);

	logic                          valid_q;
	logic [cdiv_pkg::QUO_W-1:0]    re_q, im_q;
	logic                          dz_q, clip_q;
	logic [cdiv_pkg::QUO_W-1:0]    re_val, im_val;
	logic                          re_sat, im_sat;

	function automatic logic [cdiv_pkg::QUO_W:0] finish(input cdiv_pkg::part_t p);
		logic [cdiv_pkg::QUO_W-1:0] limit;
		logic [cdiv_pkg::QUO_W-1:0] mag;
		logic                       sat;
		limit = p.neg ? HALF : HALF - cdiv_pkg::QUO_W'(1);
		sat   = p.ovf || (p.quo > limit);
		mag   = sat ? limit : p.quo;
		return {sat, p.neg ? -mag : mag};
	endfunction

	always_comb begin
		{re_sat, re_val} = finish(in_data.re);
		{im_sat, im_val} = finish(in_data.im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	// zero divisor forces zero parts and no clip
	always_ff @(posedge clk) begin
		dz_q   <= in_data.dz;
		re_q   <= in_data.dz ? '0 : re_val;
		im_q   <= in_data.dz ? '0 : im_val;
		clip_q <= !in_data.dz && (re_sat || im_sat);
	end

	assign out_valid = valid_q;
	assign out_re    = re_q;
	assign out_im    = im_q;
	assign out_dz    = dz_q;
	assign out_clip  = clip_q;

endmodule

// ===== rtl/complex_divide_top.sv =====
// ----------------------------------------------------------------------------
// complex_divide_top: pipelined fixed-point complex divider
// Depth: the result strobe done follows the item's accepting edge through
//   17 register stages end to end.
// Throughput: one item per cycle; busy stays low and the receiver cannot stall.
// Reset: arst_n clears every stage valid bit and the conjugate bit at once.
// ----------------------------------------------------------------------------
module complex_divide_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// item channel
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [cdiv_pkg::IN_WIDTH-1:0]  dividend_re,
	input  logic signed [cdiv_pkg::IN_WIDTH-1:0]  dividend_im,
	input  logic signed [cdiv_pkg::IN_WIDTH-1:0]  divisor_re,
	input  logic signed [cdiv_pkg::IN_WIDTH-1:0]  divisor_im,
	// configuration write
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic                                  cfg_data,
	// result
	output logic                                  done,
	output logic signed [cdiv_pkg::OUT_WIDTH-1:0] quotient_re,
	output logic signed [cdiv_pkg::OUT_WIDTH-1:0] quotient_im,
	output logic                                  divide_by_zero,
	output logic                                  clipped
);

	logic              conj_q;
	logic              accept;

	// stage chain: index 0 is the front end output, DIV_STAGES the last divider
	logic              stg_valid [cdiv_pkg::DIV_STAGES+1];
	cdiv_pkg::dstage_t stg_data  [cdiv_pkg::DIV_STAGES+1];

	// every stage advances each cycle, so nothing ever holds off an item
	assign busy      = 1'b0;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// conjugate-divisor select; the user must write it only while the pipe is empty (not enforced)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conj_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			conj_q <= cfg_data;
		end
	end

	// multiply, sum, take magnitude, set up the divide
	cdiv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.conj      (conj_q),
		.ar        (dividend_re),
		.ai        (dividend_im),
		.br        (divisor_re),
		.bi        (divisor_im),
		.out_valid (stg_valid[0]),
		.out_data  (stg_data[0])
	);

	// restoring divide, STEPS (two) quotient bits per stage for both parts
	for (genvar i = 0; i < cdiv_pkg::DIV_STAGES; i++) begin : g_div
		cdiv_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage_idx (cdiv_pkg::IDX_W'(i)),
			.in_valid  (stg_valid[i]),
			.in_data   (stg_data[i]),
			.out_valid (stg_valid[i+1]),
			.out_data  (stg_data[i+1])
		);
	end

	// clamp, restore sign, register the result
	cdiv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stg_valid[cdiv_pkg::DIV_STAGES]),
		.in_data   (stg_data[cdiv_pkg::DIV_STAGES]),
		.out_valid (done),
		.out_re    (quotient_re),
		.out_im    (quotient_im),
		.out_dz    (divide_by_zero),
		.out_clip  (clipped)
	);

	// every accepted item comes out after the fixed pipeline depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(cdiv_pkg::DIV_STAGES + 5) done)
		else $error("result strobe missing after pipeline depth");

	// a zero divisor gives zero parts and never a clip
	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		(done && divide_by_zero) |-> (quotient_re == '0 && quotient_im == '0 && !clipped))
		else $error("zero divisor result not cleared");

	// a rising result strobe must be preceded by a valid item in the last divider stage
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !$past(done)) |-> $past(stg_valid[cdiv_pkg::DIV_STAGES]))
		else $error("result strobe without an item in the last divider stage");

endmodule

// ===== test/complex_divide_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_divide_top_tb: self-checking bench for the pipelined complex divider
// Feeds directed corner items and a long random stream through the start/busy
// port under both divisor modes. A scoreboard predicts each quotient at the
// accepting edge and checks every done strobe in order.
// ----------------------------------------------------------------------------
module complex_divide_top_tb;

	// settle wait used after the scoreboard has emptied
	localparam int LATENCY     = 16;
	localparam int CYCLE_LIMIT = 100000;
	localparam int PHASE_ITEMS = 135;
	localparam int NUM_PHASES  = 6;

	typedef logic signed [cdiv_pkg::IN_WIDTH-1:0]  part_in_t;
	typedef logic signed [cdiv_pkg::OUT_WIDTH-1:0] part_out_t;

	// ------------------------------------------------------------------------
	// Quotient scoreboard: predicts a/b or a/conj(b) per accepted item and
	// checks done strobes against the oldest prediction.
	// ------------------------------------------------------------------------
	class quotient_board;
		typedef struct packed {
			part_out_t re;
			part_out_t im;
			logic      dz;
			logic      clip;
		} quotient_t;

		quotient_t quotient_q[$];
		bit        conjugate;
		int        mismatches;

		function new();
			conjugate  = 1'b0;
			mismatches = 0;
		endfunction

		function int pending();
			return quotient_q.size();
		endfunction

		function void report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endfunction

		// num * 2^FRAC_BITS / den, truncated toward zero, saturated
		function part_out_t scale_part(longint num, longint den, inout logic clip);
			longint mag;
			longint quo;
			longint lim;
			mag = (num < 0) ? -num : num;
			quo = (mag <<< cdiv_pkg::FRAC_BITS) / den;
			lim = (num < 0) ? (longint'(1) <<< (cdiv_pkg::OUT_WIDTH - 1))
				: (longint'(1) <<< (cdiv_pkg::OUT_WIDTH - 1)) - 1;
			if (quo > lim) begin
				clip = 1'b1;
				quo  = lim;
			end
			return part_out_t'((num < 0) ? -quo : quo);
		endfunction

		function void note_item(part_in_t ar, part_in_t ai, part_in_t br, part_in_t bi);
			longint    den;
			longint    num_re;
			longint    num_im;
			quotient_t q;
			den    = longint'(br) * br + longint'(bi) * bi;
			q      = '0;
			if (den == 0) begin
				q.dz = 1'b1;
			end else begin
				if (conjugate) begin
					num_re = longint'(ar) * br - longint'(ai) * bi;
					num_im = longint'(ai) * br + longint'(ar) * bi;
				end else begin
					num_re = longint'(ar) * br + longint'(ai) * bi;
					num_im = longint'(ai) * br - longint'(ar) * bi;
				end
				q.re = scale_part(num_re, den, q.clip);
				q.im = scale_part(num_im, den, q.clip);
			end
			quotient_q.push_back(q);
		endfunction

		function void check_result(part_out_t re, part_out_t im, logic dz, logic clip);
			quotient_t q;
			if (quotient_q.size() == 0) begin
				report("quotient strobed with no item in flight");
				return;
			end
			q = quotient_q.pop_front();
			if (re !== q.re)
				report($sformatf("quotient_re got %0d want %0d", re, q.re));
			if (im !== q.im)
				report($sformatf("quotient_im got %0d want %0d", im, q.im));
			if (dz !== q.dz)
				report($sformatf("divide_by_zero got %b want %b", dz, q.dz));
			if (clip !== q.clip)
				report($sformatf("clipped got %b want %b", clip, q.clip));
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	part_in_t  dividend_re;
	part_in_t  dividend_im;
	part_in_t  divisor_re;
	part_in_t  divisor_im;
	logic      cfg_valid;
	logic      cfg_ready;
	logic      cfg_data;
	logic      done;
	part_out_t quotient_re;
	part_out_t quotient_im;
	logic      divide_by_zero;
	logic      clipped;

	quotient_board board;
	int            items_taken;
	int            writes_taken;
	int            cycle_count;

	// corner items: zero divisors, saturation on both sides, the exact
	// negative limit, truncation of a negative quotient, full-scale parts
	int directed_set [13][4] = '{
		'{0, 0, 0, 0},
		'{32767, -32768, 0, 0},
		'{-32768, 0, 1, 0},
		'{32767, 32767, 1, 0},
		'{-2048, 0, 1, 0},
		'{2048, 0, 1, 0},
		'{2047, -2047, 1, 0},
		'{-1, 0, 3, 0},
		'{4096, 4096, 0, -1},
		'{-32768, -32768, -32768, -32768},
		'{32767, 32767, 32767, -32768},
		'{0, 0, -32768, 32767},
		'{12288, -8192, 4096, 2048}
	};

	complex_divide_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.dividend_re    (dividend_re),
		.dividend_im    (dividend_im),
		.divisor_re     (divisor_re),
		.divisor_im     (divisor_im),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.done           (done),
		.quotient_re    (quotient_re),
		.quotient_im    (quotient_im),
		.divide_by_zero (divide_by_zero),
		.clipped        (clipped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watch both channels at the edge. Every input is driven by nonblocking
	// assignment at this same edge, so the values read here are the ones the
	// block sampled. Apply a config write before noting items: none are in
	// flight across a write anyway.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				board.conjugate = cfg_data;
				writes_taken++;
			end
			if (start && !busy) begin
				board.note_item(dividend_re, dividend_im, divisor_re, divisor_im);
				items_taken++;
			end
			if (done)
				board.check_result(quotient_re, quotient_im, divide_by_zero, clipped);
		end
	end

	// hard stop if the pipeline hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Present one item and hold it until the monitor sees it taken.
	// Call at a rising edge; returns at the accepting edge.
	task automatic send_item(input part_in_t ar, input part_in_t ai,
			input part_in_t br, input part_in_t bi);
		int target;
		target = items_taken + 1;
		start       <= 1'b1;
		dividend_re <= ar;
		dividend_im <= ai;
		divisor_re  <= br;
		divisor_im  <= bi;
		wait (items_taken == target);
	endtask

	// Drop start, scramble the idle payload and wait out the requested idle time.
	task automatic idle_cycles(input int n);
		start       <= 1'b0;
		dividend_re <= part_in_t'($urandom);
		dividend_im <= part_in_t'($urandom);
		divisor_re  <= part_in_t'($urandom);
		divisor_im  <= part_in_t'($urandom);
		repeat (n) @(posedge clk);
	endtask

	// Let the pipeline empty, then write the divisor mode.
	task automatic set_mode(input logic conj);
		int target;
		idle_cycles(1);
		while (board.pending() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		target = writes_taken + 1;
		cfg_valid <= 1'b1;
		cfg_data  <= conj;
		wait (writes_taken == target);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Operand part biased toward the full-scale codes and small values.
	function automatic part_in_t rand_part();
		case ($urandom_range(9))
			0: return part_in_t'(16'h8000);
			1: return part_in_t'(16'h7fff);
			2: return part_in_t'($urandom_range(3));
			3: return part_in_t'(-int'($urandom_range(1, 3)));
			default: return part_in_t'($urandom);
		endcase
	endfunction

	task automatic send_random(input bit steady);
		part_in_t br;
		part_in_t bi;
		if (!steady && $urandom_range(99) < 30)
			idle_cycles($urandom_range(1, 2));
		case ($urandom_range(9))
			// zero divisor
			0: begin
				br = '0;
				bi = '0;
			end
			// small divisor, pushes the quotient into saturation
			1, 2: begin
				br = part_in_t'(int'($urandom_range(6)) - 3);
				bi = part_in_t'(int'($urandom_range(6)) - 3);
			end
			default: begin
				br = rand_part();
				bi = rand_part();
			end
		endcase
		send_item(rand_part(), rand_part(), br, bi);
	endtask

	initial begin
		board        = new();
		items_taken  = 0;
		writes_taken = 0;
		cycle_count  = 0;
		arst_n      <= 1'b0;
		start       <= 1'b0;
		dividend_re <= '0;
		dividend_im <= '0;
		divisor_re  <= '0;
		divisor_im  <= '0;
		cfg_valid   <= 1'b0;
		cfg_data    <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners in both modes, back to back
		for (int mode = 0; mode < 2; mode++) begin
			set_mode(mode[0]);
			foreach (directed_set[i])
				send_item(part_in_t'(directed_set[i][0]), part_in_t'(directed_set[i][1]),
					part_in_t'(directed_set[i][2]), part_in_t'(directed_set[i][3]));
		end

		// random phases, alternating the mode; run one phase with no gaps
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			set_mode(phase[0]);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_random(phase == 2);
		end

		// drain and settle
		idle_cycles(1);
		while (board.pending() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (board.pending() != 0)
			board.report("quotients never strobed");

		if (board.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
